// ===== src/smft_pkg.sv =====
// Shared constants, payload types and helpers for the sector-mapped translation block.
`timescale 1ns / 1ps
`default_nettype none
package smft_pkg;

  localparam int PHYS_SECTORS  = 2048;
  localparam int SPARE_SECTORS = 96;
  localparam int LOG_SECTORS   = PHYS_SECTORS - SPARE_SECTORS;

  localparam int PSN_W   = 11;
  localparam int MAP_AW  = $clog2(LOG_SECTORS);
  localparam int CNT_W   = PSN_W + 1;
  localparam int PROBE_W = 7;

  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_NUL   = 8'h00;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [2:0] ST_IN_PLACE   = 3'd0;
  localparam logic [2:0] ST_REMAPPED   = 3'd1;
  localparam logic [2:0] ST_READ_DATA  = 3'd2;
  localparam logic [2:0] ST_READ_FREE  = 3'd3;
  localparam logic [2:0] ST_BAD_LSN    = 3'd4;
  localparam logic [2:0] ST_SPARE_FULL = 3'd5;

  typedef struct packed {
    logic       command;
    logic [10:0] logical_sector;
    logic [7:0] write_byte;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] physical_sector;
    logic [7:0]  read_byte;
    logic [6:0]  spare_probes;
    logic        counted_write;
  } res_t;

  function automatic logic sector_free(input logic [7:0] b);
    return (b == BYTE_SPACE) || (b == BYTE_NUL);
  endfunction

endpackage
`default_nettype wire

// ===== src/smft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module smft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/sector_mapped_flash_translation.sv =====
// Sector-mapped flash translation: map table lookup, in-place write or spare-area remap.
// A bad LSN is answered in the cycle after accept. Reads and in-place writes pass the
// map and lookup states; a remapping write then scans the spare sectors (one probe per
// cycle on the single sector-store read port). busy drops in the cycle the result is
// strobed. Reset: a clearing pass over all PHYS_SECTORS (2048) sectors writes the
// identity map and empty sectors; busy stays high until it ends. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module sector_mapped_flash_translation
  import smft_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t in_data,
  output logic      out_valid,
  output res_t      out_data
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;

  localparam logic [CNT_W-1:0] LOG_CNT  = CNT_W'(LOG_SECTORS);
  localparam logic [CNT_W-1:0] PHYS_CNT = CNT_W'(PHYS_SECTORS);
  localparam logic [PSN_W-1:0] LAST_PSN = PSN_W'(PHYS_SECTORS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;          // clear index, then scan issue index
  cmd_t             cmd_r, cmd_nxt;
  logic [PSN_W-1:0] psn_r, psn_nxt;
  logic             pend_r, pend_nxt;
  logic [PSN_W-1:0] pend_cand_r, pend_cand_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;

  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [PSN_W-1:0]  map_wdata, map_rdata;
  logic              st_we;
  logic [PSN_W-1:0]  st_waddr, st_raddr;
  logic [7:0]        st_wdata, st_rdata;

  logic accept, lsn_bad, rd_free;

  smft_ram #(.WIDTH(PSN_W), .DEPTH(LOG_SECTORS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  smft_ram #(.WIDTH(8), .DEPTH(PHYS_SECTORS)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept    = start && !busy;
  assign lsn_bad   = {1'b0, in_data.logical_sector} >= LOG_CNT;
  assign rd_free   = sector_free(st_rdata);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    psn_nxt       = psn_r;
    pend_nxt      = 1'b0;
    pend_cand_nxt = pend_cand_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    map_we        = 1'b0;
    map_waddr     = cmd_r.logical_sector[MAP_AW-1:0];
    map_wdata     = pend_cand_r;
    map_raddr     = in_data.logical_sector[MAP_AW-1:0];
    st_we         = 1'b0;
    st_waddr      = psn_r;
    st_wdata      = cmd_r.write_byte;
    st_raddr      = map_rdata;

    case (state_r)
      S_CLR: begin
        map_we    = (cnt_r < LOG_CNT);
        map_waddr = cnt_r[MAP_AW-1:0];
        map_wdata = cnt_r[PSN_W-1:0];
        st_we     = 1'b1;
        st_waddr  = cnt_r[PSN_W-1:0];
        st_wdata  = BYTE_NUL;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[PSN_W-1:0] == LAST_PSN) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data;
          if (lsn_bad) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.status = ST_BAD_LSN;
          end else begin
            state_nxt = S_MAP;
          end
        end
      end
      S_MAP: begin
        psn_nxt   = map_rdata;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        out_nxt                 = '0;
        out_nxt.physical_sector = psn_r;
        if (cmd_r.command == CMD_READ) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (rd_free) begin
            out_nxt.status = ST_READ_FREE;
          end else begin
            out_nxt.status    = ST_READ_DATA;
            out_nxt.read_byte = st_rdata;
          end
        end else if (rd_free) begin
          st_we                 = 1'b1;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
          out_nxt.status        = ST_IN_PLACE;
          out_nxt.counted_write = (cmd_r.write_byte != BYTE_SPACE);
        end else begin
          cnt_nxt   = LOG_CNT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one spare read per cycle; check the one issued last cycle
        st_raddr = cnt_r[PSN_W-1:0];
        if (cnt_r < PHYS_CNT) begin
          pend_nxt      = 1'b1;
          pend_cand_nxt = cnt_r[PSN_W-1:0];
          cnt_nxt       = cnt_r + 1'b1;
        end
        if (pend_r && rd_free) begin
          st_we                   = 1'b1;
          st_waddr                = pend_cand_r;
          map_we                  = 1'b1;
          pend_nxt                = 1'b0;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
          out_nxt                 = '0;
          out_nxt.status          = ST_REMAPPED;
          out_nxt.physical_sector = pend_cand_r;
          out_nxt.spare_probes    =
            PROBE_W'({1'b0, pend_cand_r} - LOG_CNT + 1'b1);
          out_nxt.counted_write   = (cmd_r.write_byte != BYTE_SPACE);
        end else if (pend_r && pend_cand_r == LAST_PSN) begin
          pend_nxt                = 1'b0;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
          out_nxt                 = '0;
          out_nxt.status          = ST_SPARE_FULL;
          out_nxt.physical_sector = psn_r;
          out_nxt.spare_probes    = PROBE_W'(SPARE_SECTORS);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    psn_r       <= psn_nxt;
    pend_cand_r <= pend_cand_nxt;
    out_r       <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== src/smft_check.sv =====
// Port-level checks for the sector-mapped translation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module smft_check
  import smft_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t in_data,
  input wire logic out_valid,
  input wire res_t out_data
);

  localparam logic [11:0] LOG_LIM = 12'(LOG_SECTORS);

  // an out-of-range sector answers in the next cycle and leaves the block free
  a_bad_lsn: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ({1'b0, in_data.logical_sector} >= LOG_LIM)
    |=> out_valid && out_data.status == ST_BAD_LSN && !busy)
    else $error("bad lsn transaction not answered at once");

  // a valid command keeps the block busy and gives no result in the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ({1'b0, in_data.logical_sector} < LOG_LIM)
    |=> busy && !out_valid)
    else $error("valid transaction did not hold busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_SPARE_FULL)
    else $error("status code out of range");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_READ_DATA || out_data.status == ST_READ_FREE)
    |-> out_data.spare_probes == '0 && !out_data.counted_write)
    else $error("read result carries write fields");

  a_remap_probes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_REMAPPED
    |-> out_data.spare_probes != '0 && out_data.read_byte == '0)
    else $error("remap result with no probes");

endmodule

bind sector_mapped_flash_translation smft_check u_smft_check (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sector-mapped flash translation block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import smft_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    bit   known;   // result typed into the table rather than predicted
    res_t res;
  } fixed_t;

  typedef struct {
    cmd_t   cmd;
    fixed_t fix;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  cmd_t in_data = '0;
  logic busy;
  logic out_valid;
  res_t out_data;

  // predictor state
  logic [10:0] lsn_map [LOG_SECTORS];
  logic [7:0]  flash [PHYS_SECTORS];

  res_t   pending_results [$];
  fixed_t fixed_q [$];
  step_t  plan [$];
  logic [10:0] hot_lsn [16];

  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int status_seen [8];

  sector_mapped_flash_translation u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic blank(input logic [7:0] b);
    return (b == BYTE_NUL) || (b == BYTE_SPACE);
  endfunction

  // Expected outcome of one command; updates the map and flash copies.
  function automatic res_t translate(input cmd_t c);
    res_t        r;
    logic [10:0] psn;
    int          cand;
    r = '0;
    if (c.logical_sector >= LOG_SECTORS) begin
      r.status = ST_BAD_LSN;
      return r;
    end
    psn = lsn_map[c.logical_sector];
    r.physical_sector = psn;
    if (c.command == CMD_READ) begin
      if (blank(flash[psn])) begin
        r.status = ST_READ_FREE;
      end else begin
        r.status = ST_READ_DATA;
        r.read_byte = flash[psn];
      end
      return r;
    end
    if (blank(flash[psn])) begin
      flash[psn] = c.write_byte;
      r.status = ST_IN_PLACE;
      r.counted_write = (c.write_byte != BYTE_SPACE);
      return r;
    end
    // occupied: first free spare sector wins
    for (cand = LOG_SECTORS; cand < PHYS_SECTORS; cand++) begin
      r.spare_probes = r.spare_probes + 7'd1;
      if (blank(flash[cand])) begin
        flash[cand] = c.write_byte;
        lsn_map[c.logical_sector] = 11'(cand);
        r.status = ST_REMAPPED;
        r.physical_sector = 11'(cand);
        r.counted_write = (c.write_byte != BYTE_SPACE);
        return r;
      end
    end
    r.status = ST_SPARE_FULL;
    return r;
  endfunction

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected result at cycle %0d: %p", cycles, got);
      return;
    end
    want = pending_results.pop_front();
    status_seen[want.status]++;
    if (got.status !== want.status || got.physical_sector !== want.physical_sector ||
        got.read_byte !== want.read_byte || got.spare_probes !== want.spare_probes ||
        got.counted_write !== want.counted_write) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch at cycle %0d: expected %p, got %p", cycles, want, got);
    end
  endtask

  // monitor: check results, predict on every accepted transaction
  always @(posedge clk) begin
    fixed_t fx;
    res_t   pr;
    if (rst_n) begin
      if (out_valid === 1'b1)
        check_result(out_data);
      if (start && busy === 1'b0) begin
        pr = translate(in_data);
        fx.known = 1'b0;
        if (fixed_q.size() != 0)
          fx = fixed_q.pop_front();
        pending_results.push_back(fx.known ? fx.res : pr);
        accepted++;
      end
    end
  end

  function automatic res_t outcome(input logic [2:0] st, input int psn, input int rb,
                                   input int pr, input logic cw);
    res_t r;
    r.status = st;
    r.physical_sector = 11'(psn);
    r.read_byte = 8'(rb);
    r.spare_probes = 7'(pr);
    r.counted_write = cw;
    return r;
  endfunction

  function automatic step_t row(input logic cmd, input int lsn, input int wb,
                                input bit known, input res_t r);
    step_t s;
    s.cmd.command = cmd;
    s.cmd.logical_sector = 11'(lsn);
    s.cmd.write_byte = 8'(wb);
    s.fix.known = known;
    s.fix.res = r;
    return s;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   p;
    c.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    p = $urandom_range(0, 99);
    // rewrites of a few hot sectors drive the remap path
    if (p < 25)
      c.logical_sector = hot_lsn[$urandom_range(0, 15)];
    else if (p < 92)
      c.logical_sector = 11'($urandom_range(0, LOG_SECTORS - 1));
    else
      c.logical_sector = 11'($urandom_range(LOG_SECTORS, PHYS_SECTORS - 1));
    p = $urandom_range(0, 9);
    c.write_byte = (p == 0) ? BYTE_NUL : (p == 1) ? BYTE_SPACE : 8'($urandom);
    return c;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the transaction, or after the gap behind it.
  task automatic issue(input cmd_t c, input fixed_t fx, input int gap);
    fixed_q.push_back(fx);
    start <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    fixed_t none;
    int     i;
    int     n_plan;
    none.known = 1'b0;
    none.res = '0;
    for (i = 0; i < LOG_SECTORS; i++)
      lsn_map[i] = 11'(i);
    for (i = 0; i < PHYS_SECTORS; i++)
      flash[i] = BYTE_NUL;
    for (i = 0; i < 16; i++)
      hot_lsn[i] = 11'($urandom_range(0, LOG_SECTORS - 1));

    // directed table: typed results where obvious, the rest predicted
    plan.push_back(row(CMD_READ, 0, 0, 1'b1, outcome(ST_READ_FREE, 0, 0, 0, 1'b0)));
    plan.push_back(row(CMD_READ, LOG_SECTORS, 0, 1'b1,
                       outcome(ST_BAD_LSN, 0, 0, 0, 1'b0)));
    plan.push_back(row(CMD_WRITE, PHYS_SECTORS - 1, 8'h5a, 1'b1,
                       outcome(ST_BAD_LSN, 0, 0, 0, 1'b0)));
    plan.push_back(row(CMD_WRITE, 5, 8'hab, 1'b1, outcome(ST_IN_PLACE, 5, 0, 0, 1'b1)));
    plan.push_back(row(CMD_READ, 5, 0, 1'b1, outcome(ST_READ_DATA, 5, 8'hab, 0, 1'b0)));
    plan.push_back(row(CMD_WRITE, 5, 8'h11, 1'b1,
                       outcome(ST_REMAPPED, LOG_SECTORS, 0, 1, 1'b1)));
    plan.push_back(row(CMD_READ, 5, 0, 1'b1,
                       outcome(ST_READ_DATA, LOG_SECTORS, 8'h11, 0, 1'b0)));
    plan.push_back(row(CMD_WRITE, 7, BYTE_SPACE, 1'b1,
                       outcome(ST_IN_PLACE, 7, 0, 0, 1'b0)));
    plan.push_back(row(CMD_READ, 7, 0, 1'b1, outcome(ST_READ_FREE, 7, 0, 0, 1'b0)));
    plan.push_back(row(CMD_WRITE, 7, 8'h33, 1'b1, outcome(ST_IN_PLACE, 7, 0, 0, 1'b1)));
    plan.push_back(row(CMD_WRITE, LOG_SECTORS - 1, BYTE_NUL, 1'b1,
                       outcome(ST_IN_PLACE, LOG_SECTORS - 1, 0, 0, 1'b1)));
    plan.push_back(row(CMD_READ, LOG_SECTORS - 1, 0, 1'b1,
                       outcome(ST_READ_FREE, LOG_SECTORS - 1, 0, 0, 1'b0)));
    plan.push_back(row(CMD_WRITE, 9, 8'h55, 1'b0, none.res));
    plan.push_back(row(CMD_WRITE, 9, 8'h66, 1'b0, none.res));
    plan.push_back(row(CMD_WRITE, 9, 8'h77, 1'b0, none.res));
    plan.push_back(row(CMD_READ, 9, 0, 1'b0, none.res));
    plan.push_back(row(CMD_WRITE, 5, BYTE_SPACE, 1'b0, none.res));
    plan.push_back(row(CMD_READ, 5, 0, 1'b0, none.res));
    plan.push_back(row(CMD_WRITE, 7, 8'h44, 1'b0, none.res));
    plan.push_back(row(CMD_READ, 7, 0, 1'b0, none.res));
    n_plan = plan.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < n_plan; i++)
      issue(plan[i].cmd, plan[i].fix, pick_gap());
    drain();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2)
        drain();
      // the first 20 of every 100 items run back to back
      issue(rand_cmd(), none, ((i % 100) < 20) ? 0 : pick_gap());
    end
    drain();
    repeat (4) @(posedge clk);

    if (pending_results.size() != 0 || accepted != n_plan + RANDOM_ITEMS)
      errors++;

    $display("ran %0d transactions: directed table, then random reads and writes with",
             accepted);
    $display("hot-sector rewrites (in place %0d, remap %0d, data %0d, free %0d, bad %0d, full %0d)",
             status_seen[ST_IN_PLACE], status_seen[ST_REMAPPED], status_seen[ST_READ_DATA],
             status_seen[ST_READ_FREE], status_seen[ST_BAD_LSN], status_seen[ST_SPARE_FULL]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
